// ===== hdl/drbt_pkg.sv =====
// types, codes and constants shared by the rank/bank timing update block
package drbt_pkg;

	localparam int CYC_W      = 48;
	localparam int REG_W      = 6;
	localparam int OFF_W      = 8;
	localparam int CFG_ADDR_W = 3;
	localparam int FUNC_W     = 3;
	localparam int GRP_W      = 2;
	localparam int BIDX_W     = 4;

	// command codes
	localparam logic [FUNC_W-1:0] FUNC_ACT  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_RD   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_RDA  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_WR   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_WRA  = 3'd4;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_RRD_S  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CCD_S  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BL     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_CL     = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_RTW    = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_CWL    = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_WTR_S  = 3'd6;

	// register reset values
	localparam logic [REG_W-1:0] RST_RRD_S = 6'd4;
	localparam logic [REG_W-1:0] RST_CCD_S = 6'd4;
	localparam logic [REG_W-1:0] RST_BL    = 6'd4;
	localparam logic [REG_W-1:0] RST_CL    = 6'd16;
	localparam logic [REG_W-1:0] RST_RTW   = 6'd8;
	localparam logic [REG_W-1:0] RST_CWL   = 6'd12;
	localparam logic [REG_W-1:0] RST_WTR_S = 6'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [GRP_W-1:0]  issuing_group;
		logic [CYC_W-1:0]  issue_cycle;
	} in_t;

	typedef struct packed {
		logic [BIDX_W-1:0] bank_index;
		logic [CYC_W-1:0]  next_act;
		logic [CYC_W-1:0]  next_read;
		logic [CYC_W-1:0]  next_read_auto;
		logic [CYC_W-1:0]  next_write;
		logic [CYC_W-1:0]  next_write_auto;
		logic              last_bank;
	} out_t;

	// cross-group offsets derived from the timing registers
	typedef struct packed {
		logic [OFF_W-1:0] act_act;
		logic [OFF_W-1:0] col_col;
		logic [OFF_W-1:0] rd_wr;
		logic [OFF_W-1:0] wr_rd;
	} tim_t;

	// per-bank entry: the read and write pairs always move together
	typedef struct packed {
		logic [CYC_W-1:0] act;
		logic [CYC_W-1:0] rd;
		logic [CYC_W-1:0] wr;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OFFS,
		ST_ADD_A,
		ST_ADD_B,
		ST_SWEEP
	} state_t;

endpackage

// ===== hdl/drbt_regs.sv =====
// timing register file and derived cross-group offsets
module drbt_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [drbt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [drbt_pkg::REG_W-1:0]       cfg_data,
	output drbt_pkg::tim_t                   tim
);
	import drbt_pkg::*;

	logic [REG_W-1:0] rrd_q, ccd_q, bl_q, cl_q, rtw_q, cwl_q, wtr_q;
	logic [OFF_W-1:0] rw_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rrd_q <= RST_RRD_S;
			ccd_q <= RST_CCD_S;
			bl_q  <= RST_BL;
			cl_q  <= RST_CL;
			rtw_q <= RST_RTW;
			cwl_q <= RST_CWL;
			wtr_q <= RST_WTR_S;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_RRD_S: rrd_q <= cfg_data;
				REG_CCD_S: ccd_q <= cfg_data;
				REG_BL:    bl_q  <= cfg_data;
				REG_CL:    cl_q  <= cfg_data;
				REG_RTW:   rtw_q <= cfg_data;
				REG_CWL:   cwl_q <= cfg_data;
				REG_WTR_S: wtr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		rw_pos       = OFF_W'(cl_q) + OFF_W'(bl_q) + OFF_W'(rtw_q);
		tim.act_act  = OFF_W'(rrd_q);
		tim.col_col  = (ccd_q > bl_q) ? OFF_W'(ccd_q) : OFF_W'(bl_q);
		// read to write turnaround clamps at zero
		tim.rd_wr    = (rw_pos > OFF_W'(cwl_q)) ? rw_pos - OFF_W'(cwl_q) : '0;
		tim.wr_rd    = OFF_W'(cwl_q) + OFF_W'(bl_q) + OFF_W'(wtr_q);
	end

endmodule

// ===== hdl/dram_rank_bank_timing_update_core.sv =====
// rank timing tracker: raises per-bank earliest-issue cycles of the other bank groups
//
//  channel | direction | handshake               | beat
//  cmd     | in        | cmd_valid / cmd_ready   | in_t: func, issuing_group, issue_cycle
//  row     | out       | row_valid / row_ready   | out_t: one bank's entries, last_bank on final
//  cfg     | in        | cfg_we                  | cfg_addr selects register, cfg_data value
//
// an item runs through setup (offset select, then two passes through the shared 48-bit
// saturating adder), then visits each bank of the other groups through the entry
// memory read / max / write-back loop, one bank per cycle while the output is not stalled;
// the next item is accepted only once the sweep has returned to idle.
// an issuing group with no other groups to visit, or out of range, returns to idle
// right after the offset select cycle.
// reset clears per-bank valid bits, so entries read as zero without a clearing pass.
// a stalled output register holds the sweep; cmd_ready is high only between items.
module dram_rank_bank_timing_update_core #(
	parameter int GROUP_COUNT     = 4,
	parameter int BANKS_PER_GROUP = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  drbt_pkg::in_t                    cmd_data,
	output logic                             row_valid,
	input  logic                             row_ready,
	output drbt_pkg::out_t                   row_data,
	input  logic                             cfg_we,
	input  logic [drbt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [drbt_pkg::REG_W-1:0]       cfg_data
);
	import drbt_pkg::*;

	localparam int NB   = GROUP_COUNT * BANKS_PER_GROUP;
	localparam int BK_W = (NB > 1) ? $clog2(NB) : 1;
	localparam int K_W  = (BANKS_PER_GROUP > 1) ? $clog2(BANKS_PER_GROUP) : 1;
	localparam int GC_W = $clog2(GROUP_COUNT + 3);

	tim_t              tim;
	state_t            state_q, state_nx;

	logic [FUNC_W-1:0] func_q;
	logic [GRP_W-1:0]  grp_q;
	logic [CYC_W-1:0]  t_q;
	logic [OFF_W-1:0]  off_a_q, off_b_q;
	logic [CYC_W-1:0]  floor_a_q, floor_b_q;
	logic [GC_W-1:0]   g_q, g_nx, g_first;
	logic [K_W-1:0]    k_q, k_nx;
	logic [BK_W-1:0]   bank_cur, bank_nx, rd_addr;

	entry_t            mem_q [NB];
	logic [NB-1:0]     vld_q;
	entry_t            rd_data_q;
	logic              rd_hit_q;

	logic              cmd_ok, last_cur, out_free;
	logic              rd_en, out_load, add_sel_b;
	logic              is_act, is_col, raise_a, raise_b;
	logic [CYC_W-1:0]  cmp_a_lhs;
	logic [CYC_W:0]    sum;
	logic [CYC_W-1:0]  sat_sum;
	entry_t            cur, upd;

	out_t              out_q;
	logic              out_valid_q;

	drbt_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.tim      (tim)
	);

	// bank walk over the groups other than the issuing one
	always_comb begin
		g_first = (grp_q == '0) ? GC_W'(1) : '0;
		cmd_ok  = (GC_W'(grp_q) < GC_W'(GROUP_COUNT)) && (g_first < GC_W'(GROUP_COUNT));
		if (k_q == K_W'(BANKS_PER_GROUP - 1)) begin
			k_nx = '0;
			g_nx = g_q + GC_W'(1);
			if (g_nx == GC_W'(grp_q)) begin
				g_nx = g_nx + GC_W'(1);
			end
		end else begin
			k_nx = k_q + K_W'(1);
			g_nx = g_q;
		end
		last_cur = (g_nx >= GC_W'(GROUP_COUNT));
		bank_cur = BK_W'(32'(g_q) * BANKS_PER_GROUP + 32'(k_q));
		bank_nx  = BK_W'(32'(g_nx) * BANKS_PER_GROUP + 32'(k_nx));
	end

	assign out_free = !out_valid_q || row_ready;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (cmd_valid) state_nx = ST_OFFS;
			ST_OFFS:  state_nx = cmd_ok ? ST_ADD_A : ST_IDLE;
			ST_ADD_A: state_nx = ST_ADD_B;
			ST_ADD_B: state_nx = ST_SWEEP;
			ST_SWEEP: if (out_free && last_cur) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_ready = 1'b0;
		add_sel_b = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = bank_nx;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:  cmd_ready = 1'b1;
			ST_OFFS:  ;
			ST_ADD_A: ;
			ST_ADD_B: begin
				add_sel_b = 1'b1;
				rd_en     = 1'b1;
				rd_addr   = bank_cur;
			end
			ST_SWEEP: begin
				out_load = out_free;
				rd_en    = out_free && !last_cur;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// command capture and offset selection
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			func_q <= cmd_data.func;
			grp_q  <= cmd_data.issuing_group;
			t_q    <= cmd_data.issue_cycle;
		end
		if (state_q == ST_OFFS) begin
			g_q <= g_first;
			k_q <= '0;
			case (func_q)
				FUNC_RD, FUNC_RDA: begin
					off_a_q <= tim.col_col;
					off_b_q <= tim.rd_wr;
				end
				FUNC_WR, FUNC_WRA: begin
					off_a_q <= tim.wr_rd;
					off_b_q <= tim.col_col;
				end
				default: begin
					off_a_q <= tim.act_act;
					off_b_q <= tim.act_act;
				end
			endcase
		end else if (out_load && !last_cur) begin
			g_q <= g_nx;
			k_q <= k_nx;
		end
	end

	// shared saturating adder: issue cycle plus offset
	always_comb begin
		sum     = {1'b0, t_q} + (CYC_W + 1)'(add_sel_b ? off_b_q : off_a_q);
		sat_sum = sum[CYC_W] ? '1 : sum[CYC_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADD_A) floor_a_q <= sat_sum;
		if (state_q == ST_ADD_B) floor_b_q <= sat_sum;
	end

	// entry memory with registered read
	always_ff @(posedge clk) begin
		if (out_load) begin
			mem_q[bank_cur] <= upd;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (out_load) vld_q[bank_cur] <= 1'b1;
			if (rd_en)    rd_hit_q        <= vld_q[rd_addr];
		end
	end

	// max against the floors, one bank per cycle unless the output register stalls
	always_comb begin
		cur       = rd_hit_q ? rd_data_q : '0;
		is_act    = (func_q == FUNC_ACT);
		is_col    = (func_q == FUNC_RD) || (func_q == FUNC_RDA) ||
		            (func_q == FUNC_WR) || (func_q == FUNC_WRA);
		cmp_a_lhs = is_act ? cur.act : cur.rd;
		raise_a   = floor_a_q > cmp_a_lhs;
		raise_b   = floor_b_q > cur.wr;
		upd.act   = (is_act && raise_a) ? floor_a_q : cur.act;
		upd.rd    = (is_col && raise_a) ? floor_a_q : cur.rd;
		upd.wr    = (is_col && raise_b) ? floor_b_q : cur.wr;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (row_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.bank_index      <= BIDX_W'(bank_cur);
			out_q.next_act        <= upd.act;
			out_q.next_read       <= upd.rd;
			out_q.next_read_auto  <= upd.rd;
			out_q.next_write      <= upd.wr;
			out_q.next_write_auto <= upd.wr;
			out_q.last_bank       <= last_cur;
		end
	end

	assign row_valid = out_valid_q;
	assign row_data  = out_q;

	// the sweep never visits the issuing group
	a_skip_issuer: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (g_q != GC_W'(grp_q)))
		else $error("sweep touched the issuing bank group");

	// the final beat of a command ends the sweep
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_cur) |=> (state_q == ST_IDLE))
		else $error("sweep did not end after the last bank");

	// entries only ever move forward
	a_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (upd.act >= cur.act && upd.rd >= cur.rd && upd.wr >= cur.wr))
		else $error("entry moved backward");

	// an accepted command always starts with offset selection
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (state_q == ST_OFFS))
		else $error("accepted command did not start the sequence");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking bench for the rank/bank cross-group timing update core
module testbench;
	import drbt_pkg::*;

	localparam int GROUPS        = 4;
	localparam int BANKS_PER_GRP = 4;
	localparam int BANKS         = GROUPS * BANKS_PER_GRP;
	localparam int NREGS         = 7;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_REPORTS   = 100;
	localparam logic [63:0] CYC_MAX = {16'd0, {CYC_W{1'b1}}};

	// the five earliest-issue entries kept per bank
	localparam int SLOT_ACT  = 0;
	localparam int SLOT_RD   = 1;
	localparam int SLOT_RDA  = 2;
	localparam int SLOT_WR   = 3;
	localparam int SLOT_WRA  = 4;
	localparam int NSLOTS    = 5;

	// codes above the column commands leave the entries alone
	localparam logic [FUNC_W-1:0] FUNC_NOP_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_NOP_HI = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_ready;
	in_t                   cmd_data  = '0;
	logic                  row_valid;
	logic                  row_ready = 1'b0;
	out_t                  row_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [REG_W-1:0]      cfg_data  = '0;

	dram_rank_bank_timing_update_core #(
		.GROUP_COUNT(GROUPS),
		.BANKS_PER_GROUP(BANKS_PER_GRP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_data(cmd_data),
		.row_valid(row_valid),
		.row_ready(row_ready),
		.row_data(row_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

	// predictor state: timing registers and per-bank earliest cycles
	logic [REG_W-1:0] r_rrd = RST_RRD_S;
	logic [REG_W-1:0] r_ccd = RST_CCD_S;
	logic [REG_W-1:0] r_bl  = RST_BL;
	logic [REG_W-1:0] r_cl  = RST_CL;
	logic [REG_W-1:0] r_rtw = RST_RTW;
	logic [REG_W-1:0] r_cwl = RST_CWL;
	logic [REG_W-1:0] r_wtr = RST_WTR_S;
	logic [CYC_W-1:0] earliest [BANKS][NSLOTS];

	in_t  cmd_q [$];
	out_t bank_rows_due [$];

	int   cmds_queued   = 0;
	int   cmds_accepted = 0;
	int   rows_checked  = 0;
	int   fails         = 0;
	int   settings_used = 1;
	bit   in_beat       = 1'b0;
	logic [CYC_W-1:0] now_cycle = '0;

	initial begin
		for (int b = 0; b < BANKS; b++)
			for (int s = 0; s < NSLOTS; s++)
				earliest[b][s] = '0;
	end

	function automatic logic [CYC_W-1:0] sat_add(input logic [CYC_W-1:0] a,
			input logic [63:0] b);
		logic [63:0] s;
		s = {16'd0, a} + b;
		return (s > CYC_MAX) ? CYC_MAX[CYC_W-1:0] : s[CYC_W-1:0];
	endfunction

	function automatic logic [CYC_W-1:0] later(input logic [CYC_W-1:0] a, b);
		return (a > b) ? a : b;
	endfunction

	// a read/write pair always ends up equal: the larger of both and the floor
	function automatic void raise_pair(input int bank, input int first,
			input logic [CYC_W-1:0] floor_cyc);
		logic [CYC_W-1:0] v;
		v = later(later(earliest[bank][first], earliest[bank][first + 1]), floor_cyc);
		earliest[bank][first]     = v;
		earliest[bank][first + 1] = v;
	endfunction

	task automatic apply_command(input in_t cmd);
		logic [CYC_W-1:0] t;
		logic [63:0]      col, rw_sum, rw, wr_rd;
		out_t             row;
		int               last_grp, bank;
		t        = cmd.issue_cycle;
		col      = (r_ccd > r_bl) ? 64'(r_ccd) : 64'(r_bl);
		rw_sum   = 64'(r_cl) + 64'(r_bl) + 64'(r_rtw);
		// read-to-write offset clamps at zero when write latency dominates
		rw       = (rw_sum > 64'(r_cwl)) ? rw_sum - 64'(r_cwl) : 64'd0;
		wr_rd    = 64'(r_cwl) + 64'(r_bl) + 64'(r_wtr);
		last_grp = (cmd.issuing_group == GROUPS - 1) ? GROUPS - 2 : GROUPS - 1;
		for (int g = 0; g < GROUPS; g++) begin
			if (g != cmd.issuing_group) begin
				for (int k = 0; k < BANKS_PER_GRP; k++) begin
					bank = g * BANKS_PER_GRP + k;
					case (cmd.func)
						FUNC_ACT: begin
							earliest[bank][SLOT_ACT] = later(earliest[bank][SLOT_ACT],
								sat_add(t, 64'(r_rrd)));
						end
						FUNC_RD, FUNC_RDA: begin
							raise_pair(bank, SLOT_RD, sat_add(t, col));
							raise_pair(bank, SLOT_WR, sat_add(t, rw));
						end
						FUNC_WR, FUNC_WRA: begin
							raise_pair(bank, SLOT_RD, sat_add(t, wr_rd));
							raise_pair(bank, SLOT_WR, sat_add(t, col));
						end
						default: ;
					endcase
					row.bank_index      = BIDX_W'(bank);
					row.next_act        = earliest[bank][SLOT_ACT];
					row.next_read       = earliest[bank][SLOT_RD];
					row.next_read_auto  = earliest[bank][SLOT_RDA];
					row.next_write      = earliest[bank][SLOT_WR];
					row.next_write_auto = earliest[bank][SLOT_WRA];
					row.last_bank       = (g == last_grp && k == BANKS_PER_GRP - 1);
					bank_rows_due = {bank_rows_due, row};
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [CYC_W-1:0] want, got);
		if (want !== got) begin
			fails++;
			if (fails <= MAX_REPORTS)
				$display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// monitor: predicts on each accepted command, checks each result beat
	always @(posedge clk) begin
		out_t want;
		in_beat = cmd_valid && cmd_ready;
		if (in_beat) begin
			apply_command(cmd_data);
			cmds_accepted++;
		end
		if (row_valid && row_ready) begin
			if (bank_rows_due.size() == 0) begin
				fails++;
				$display("%0t unexpected beat: expected none, got bank %0d", $time,
					row_data.bank_index);
			end else begin
				want = bank_rows_due.pop_front();
				rows_checked++;
				check_field("bank_index", CYC_W'(want.bank_index),
					CYC_W'(row_data.bank_index));
				check_field("next_act", want.next_act, row_data.next_act);
				check_field("next_read", want.next_read, row_data.next_read);
				check_field("next_read_auto", want.next_read_auto, row_data.next_read_auto);
				check_field("next_write", want.next_write, row_data.next_write);
				check_field("next_write_auto", want.next_write_auto,
					row_data.next_write_auto);
				check_field("last_bank", CYC_W'(want.last_bank), CYC_W'(row_data.last_bank));
			end
		end
	end

	// driver: bursts of commands with random gaps between them
	int burst_left = 0;
	int gap_left   = 0;

	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || in_beat)) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				cmd_data  <= cmd_q.pop_front();
				cmd_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 8);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// receiver: switches between always ready, coin flips and long stalls
	int sink_mode  = 0;
	int mode_left  = 0;
	int stall_left = 0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			mode_left = $urandom_range(50, 200);
			sink_mode = $urandom_range(0, 2);
		end else begin
			mode_left--;
		end
		if (stall_left != 0) begin
			stall_left--;
			row_ready <= 1'b0;
		end else begin
			case (sink_mode)
				0: row_ready <= 1'b1;
				1: row_ready <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 15) == 0)
						stall_left = $urandom_range(4, 20);
					row_ready <= (stall_left == 0);
				end
			endcase
		end
	end

	task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic [GRP_W-1:0] grp,
			input logic [CYC_W-1:0] cyc);
		in_t c;
		c.func          = func;
		c.issuing_group = grp;
		c.issue_cycle   = cyc;
		cmd_q = {cmd_q, c};
		cmds_queued++;
	endtask

	task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_RRD_S: r_rrd = val;
			REG_CCD_S: r_ccd = val;
			REG_BL:    r_bl  = val;
			REG_CL:    r_cl  = val;
			REG_RTW:   r_rtw = val;
			REG_CWL:   r_cwl = val;
			REG_WTR_S: r_wtr = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every command and result, then let the core settle
	task automatic drain();
		while (cmds_accepted != cmds_queued || bank_rows_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly real traffic near a moving cycle count, some older issues and noise codes
	task automatic random_cmds(input int n);
		logic [CYC_W-1:0] t;
		repeat (n) begin
			if ($urandom_range(0, 9) == 0) begin
				t = {16'($urandom), 32'($urandom)};
				queue_cmd(FUNC_W'($urandom_range(FUNC_NOP_LO, FUNC_NOP_HI)),
					GRP_W'($urandom_range(0, GROUPS - 1)), t);
			end else begin
				now_cycle = now_cycle + CYC_W'($urandom_range(0, 24));
				t = now_cycle;
				if ($urandom_range(0, 4) == 0 && now_cycle > CYC_W'(64))
					t = now_cycle - CYC_W'($urandom_range(0, 64));
				queue_cmd(FUNC_W'($urandom_range(FUNC_ACT, FUNC_WRA)),
					GRP_W'($urandom_range(0, GROUPS - 1)), t);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset timings: every code once, spread over all groups, small and top cycles
		for (int f = 0; f <= FUNC_NOP_HI; f++)
			queue_cmd(FUNC_W'(f), GRP_W'(f % GROUPS), CYC_W'(f * 5));
		queue_cmd(FUNC_RDA, 2'd3, 48'd40);
		queue_cmd(FUNC_WRA, 2'd0, 48'd41);
		queue_cmd(FUNC_RD, 2'd2, 48'd2);
		queue_cmd(FUNC_WR, 2'd1, 48'd3);
		queue_cmd(FUNC_NOP_HI, 2'd3, {CYC_W{1'b1}});
		queue_cmd(FUNC_ACT, 2'd3, 48'd100);
		queue_cmd(FUNC_RD, 2'd0, 48'd100);
		queue_cmd(FUNC_WR, 2'd3, 48'd101);
		now_cycle = 48'd200;
		random_cmds(32);
		drain();

		// all timings at zero
		for (int i = 0; i < NREGS; i++)
			write_cfg(CFG_ADDR_W'(i), '0);
		settings_used++;
		now_cycle = now_cycle + 48'd4096;
		random_cmds(32);
		drain();

		// all timings at their maximum, plus a write to the unused index
		for (int i = 0; i < NREGS; i++)
			write_cfg(CFG_ADDR_W'(i), {REG_W{1'b1}});
		write_cfg(CFG_ADDR_W'(NREGS), 6'd1);
		settings_used++;
		now_cycle = now_cycle + CYC_W'($urandom_range(1 << 20, 1 << 30));
		random_cmds(32);
		drain();

		// write latency beyond read latency + burst + gap: offset clamps to zero
		write_cfg(REG_CL, 6'd0);
		write_cfg(REG_BL, 6'd1);
		write_cfg(REG_RTW, 6'd2);
		write_cfg(REG_CWL, 6'd63);
		write_cfg(REG_CCD_S, REG_W'($urandom_range(0, 63)));
		write_cfg(REG_RRD_S, REG_W'($urandom_range(0, 63)));
		write_cfg(REG_WTR_S, REG_W'($urandom_range(0, 63)));
		settings_used++;
		now_cycle = now_cycle + {12'd0, 4'($urandom), 32'($urandom)};
		queue_cmd(FUNC_RD, 2'd1, now_cycle + 48'd500);
		queue_cmd(FUNC_RDA, 2'd2, now_cycle + 48'd520);
		now_cycle = now_cycle + 48'd600;
		random_cmds(32);
		drain();

		// random timings, top cycle bit set from here on
		for (int i = 0; i < NREGS; i++)
			write_cfg(CFG_ADDR_W'(i), REG_W'($urandom_range(0, 63)));
		write_cfg(CFG_ADDR_W'(NREGS), REG_W'($urandom_range(0, 63)));
		settings_used++;
		now_cycle = {1'b1, 7'd0, 8'($urandom), 32'($urandom)};
		random_cmds(32);

		// saturation at the cycle range, kept last since the entries stay pinned
		queue_cmd(FUNC_ACT, 2'd0, {CYC_W{1'b1}});
		queue_cmd(FUNC_RD, 2'd1, {CYC_W{1'b1}});
		queue_cmd(FUNC_WR, 2'd2, {CYC_W{1'b1}});
		queue_cmd(FUNC_NOP_LO, 2'd3, {CYC_W{1'b1}});
		queue_cmd(FUNC_RDA, 2'd3, {CYC_W{1'b1}} - 48'd10);
		queue_cmd(FUNC_WRA, 2'd0, {CYC_W{1'b1}} - 48'd3);
		drain();

		$display("%0d commands over %0d timing settings, %0d bank beats checked",
			cmds_accepted, settings_used, rows_checked);
		$display("%0d field mismatches", fails);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== dram_rank_bank_timing_update_core.f =====
hdl/drbt_pkg.sv
hdl/drbt_regs.sv
hdl/dram_rank_bank_timing_update_core.sv
tb/sv/testbench.sv
